### sv/thc_pkg.sv
// ============================================================================
// thc_pkg
// shared widths, types and constants of the tilt-compensated heading block
// ============================================================================
`default_nettype none

package thc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    localparam int FIELD_W  = 16;
    localparam int PROD_W   = 32;
    localparam int SUMC_W   = 33;
    localparam int PA_W     = 48;
    localparam int PB_W     = 49;
    localparam int HY_W     = 47;
    localparam int HY_SHIFT = 14;
    localparam int HV_W     = 49;
    localparam int MAG_W    = 48;
    localparam int NORM_BIT = 46;
    localparam int SHIFT_W  = 6;
    localparam int CW       = 52;
    localparam int ANG_W    = 32;
    localparam int RND_W    = ANG_W + 1;
    localparam int FRAC_DROP = 16;
    localparam int SUM_W    = 17;

    typedef logic signed [FIELD_W-1:0]  field_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUMC_W-1:0]   sumc_t;
    typedef logic signed [PA_W-1:0]     pa_t;
    typedef logic signed [PB_W-1:0]     pb_t;
    typedef logic signed [HY_W-1:0]     hy_t;
    typedef logic signed [HV_W-1:0]     hv_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic        [SHIFT_W-1:0]  shift_t;
    typedef logic signed [CW-1:0]       cw_t;
    typedef logic signed [ANG_W-1:0]    ang_t;
    typedef logic signed [RND_W-1:0]    rnd_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } pipe_ctl_t;

    localparam prod_t ONE_Q28    = 32'sd268435456;
    localparam ang_t  ANG_PI_2   = 32'sd843314857;
    localparam rnd_t  ROUND_HALF = 33'sd32768;
    localparam sum_t  HEAD_PI    = 17'sd25736;
    localparam sum_t  HEAD_2PI   = 17'sd51472;
    localparam sum_t  HEAD_CLAMP = 17'sd25805;

    localparam ang_t ATAN_TABLE [24] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

endpackage

`default_nettype wire

### sv/thc_tilt.sv
// ============================================================================
// thc_tilt
// four-stage datapath forming the tilt-compensated horizontal field vector
// ============================================================================
`default_nettype none

module thc_tilt
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  thc_pkg::field_t      fx,
    input  thc_pkg::field_t      fy,
    input  thc_pkg::field_t      fz,
    input  thc_pkg::field_t      cx,
    input  thc_pkg::field_t      cy,
    input  thc_pkg::field_t      cz,
    output logic                 hv_valid,
    output thc_pkg::hv_t         hx,
    output thc_pkg::hv_t         hy_neg
);

    logic            v1_reg, v2_reg, v3_reg, v4_reg;

    thc_pkg::prod_t  cxx_reg, fycy_reg, fzcz_reg, fycz_reg, fzcy_reg;
    thc_pkg::field_t fx1_reg, cx1_reg;

    thc_pkg::prod_t  cpsq_reg;
    thc_pkg::sumc_t  sumc_reg, diff_reg;
    thc_pkg::field_t fx2_reg, cx2_reg;

    thc_pkg::pa_t    pa_reg;
    thc_pkg::pb_t    pb_reg;
    thc_pkg::hy_t    hy3_reg;

    thc_pkg::hv_t    x_reg, y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products of field and dcm row
            cxx_reg  <= thc_pkg::prod_t'(cx) * thc_pkg::prod_t'(cx);
            fycy_reg <= thc_pkg::prod_t'(fy) * thc_pkg::prod_t'(cy);
            fzcz_reg <= thc_pkg::prod_t'(fz) * thc_pkg::prod_t'(cz);
            fycz_reg <= thc_pkg::prod_t'(fy) * thc_pkg::prod_t'(cz);
            fzcy_reg <= thc_pkg::prod_t'(fz) * thc_pkg::prod_t'(cy);
            fx1_reg  <= fx;
            cx1_reg  <= cx;

            // sums
            cpsq_reg <= thc_pkg::ONE_Q28 - cxx_reg;
            sumc_reg <= thc_pkg::sumc_t'(fycy_reg) + thc_pkg::sumc_t'(fzcz_reg);
            diff_reg <= thc_pkg::sumc_t'(fycz_reg) - thc_pkg::sumc_t'(fzcy_reg);
            fx2_reg  <= fx1_reg;
            cx2_reg  <= cx1_reg;

            // second products
            pa_reg  <= thc_pkg::pa_t'(fx2_reg) * thc_pkg::pa_t'(cpsq_reg);
            pb_reg  <= thc_pkg::pb_t'(cx2_reg) * thc_pkg::pb_t'(sumc_reg);
            hy3_reg <= thc_pkg::hy_t'(diff_reg) <<< thc_pkg::HY_SHIFT;

            // horizontal vector, y negated for atan2(-y, x)
            x_reg <= thc_pkg::hv_t'(pa_reg) - pb_reg;
            y_reg <= -thc_pkg::hv_t'(hy3_reg);
        end
    end

    assign hv_valid = v4_reg;
    assign hx       = x_reg;
    assign hy_neg   = y_reg;

endmodule

`default_nettype wire

### sv/thc_norm.sv
// ============================================================================
// thc_norm
// two-stage normalizer: shift count search, then shift and quadrant fold
// ============================================================================
`default_nettype none

module thc_norm
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            hv_valid,
    input  thc_pkg::hv_t         hx,
    input  thc_pkg::hv_t         hy_neg,
    output thc_pkg::pipe_ctl_t   ctl_out,
    output thc_pkg::cw_t         x_out,
    output thc_pkg::cw_t         y_out,
    output thc_pkg::ang_t        z_out
);

    thc_pkg::hv_t       nx, ny;
    thc_pkg::mag_t      magx, magy, mag_or;
    thc_pkg::shift_t    k_next;

    thc_pkg::pipe_ctl_t ctl_a_reg, ctl_b_reg;
    thc_pkg::hv_t       xa_reg, ya_reg;
    thc_pkg::shift_t    k_reg;

    thc_pkg::cw_t       xs, ys, x_next, y_next;
    thc_pkg::ang_t      z_next;
    thc_pkg::cw_t       x_reg, y_reg;
    thc_pkg::ang_t      z_reg;

    // leading-one search over the combined magnitude
    always_comb
    begin
        nx     = -hx;
        ny     = -hy_neg;
        magx   = hx[thc_pkg::HV_W-1] ? nx[thc_pkg::MAG_W-1:0] : hx[thc_pkg::MAG_W-1:0];
        magy   = hy_neg[thc_pkg::HV_W-1] ? ny[thc_pkg::MAG_W-1:0]
                                         : hy_neg[thc_pkg::MAG_W-1:0];
        mag_or = magx | magy;
        k_next = '0;
        for (int i = 0; i < thc_pkg::NORM_BIT; i++)
        begin
            if (mag_or[i])
            begin
                k_next = thc_pkg::shift_t'(thc_pkg::NORM_BIT - i);
            end
        end
        if (mag_or[thc_pkg::MAG_W-1:thc_pkg::NORM_BIT] != '0)
        begin
            k_next = '0;
        end
    end

    // shift and fold left half-plane onto the right
    always_comb
    begin
        xs     = thc_pkg::cw_t'(xa_reg) <<< k_reg;
        ys     = thc_pkg::cw_t'(ya_reg) <<< k_reg;
        x_next = xs;
        y_next = ys;
        z_next = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x_next = ys;
                y_next = -xs;
                z_next = thc_pkg::ANG_PI_2;
            end
            else
            begin
                x_next = -ys;
                y_next = xs;
                z_next = -thc_pkg::ANG_PI_2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg.valid <= hv_valid;
            ctl_a_reg.zero  <= (hx == '0) && (hy_neg == '0);
            ctl_b_reg       <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg <= hx;
            ya_reg <= hy_neg;
            k_reg  <= k_next;
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

### sv/thc_cordic.sv
// ============================================================================
// thc_cordic
// vectoring cordic, one registered micro-rotation per stage
// ============================================================================
`default_nettype none

module thc_cordic
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  thc_pkg::pipe_ctl_t   ctl_in,
    input  thc_pkg::cw_t         x_in,
    input  thc_pkg::cw_t         y_in,
    input  thc_pkg::ang_t        z_in,
    output thc_pkg::pipe_ctl_t   ctl_out,
    output thc_pkg::ang_t        z_out
);

    thc_pkg::pipe_ctl_t ctl_reg [thc_pkg::CORDIC_N];
    thc_pkg::cw_t       x_reg   [thc_pkg::CORDIC_N];
    thc_pkg::cw_t       y_reg   [thc_pkg::CORDIC_N];
    thc_pkg::ang_t      z_reg   [thc_pkg::CORDIC_N];

    for (genvar i = 0; i < thc_pkg::CORDIC_N; i++)
    begin : g_step
        thc_pkg::pipe_ctl_t c_src;
        thc_pkg::cw_t       x_src, y_src, xs, ys, x_next, y_next;
        thc_pkg::ang_t      z_src, z_next;

        if (i == 0)
        begin : g_first
            assign c_src = ctl_in;
            assign x_src = x_in;
            assign y_src = y_in;
            assign z_src = z_in;
        end
        else
        begin : g_rest
            assign c_src = ctl_reg[i-1];
            assign x_src = x_reg[i-1];
            assign y_src = y_reg[i-1];
            assign z_src = z_reg[i-1];
        end

        always_comb
        begin
            xs = x_src >>> i;
            ys = y_src >>> i;
            if (y_src > 0)
            begin
                x_next = x_src + ys;
                y_next = y_src - xs;
                z_next = z_src + thc_pkg::ATAN_TABLE[i];
            end
            else
            begin
                x_next = x_src - ys;
                y_next = y_src + xs;
                z_next = z_src - thc_pkg::ATAN_TABLE[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else if (en)
            begin
                ctl_reg[i] <= c_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign ctl_out = ctl_reg[thc_pkg::CORDIC_N-1];
    assign z_out   = z_reg[thc_pkg::CORDIC_N-1];

endmodule

`default_nettype wire

### sv/thc_output.sv
// ============================================================================
// thc_output
// rounding to q3.13 with clamp, then declination add and, if it is nonzero, wrap into +-pi
// ============================================================================
`default_nettype none

module thc_output
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  thc_pkg::pipe_ctl_t   ctl_in,
    input  thc_pkg::ang_t        z_in,
    input  thc_pkg::field_t      decl,
    output logic                 out_valid,
    output thc_pkg::field_t      heading
);

    thc_pkg::rnd_t   zb;
    thc_pkg::sum_t   r, h_next;
    thc_pkg::sum_t   s, s_next;

    logic            va_reg, vb_reg;
    thc_pkg::field_t h_reg, heading_reg;

    always_comb
    begin
        zb = ctl_in.zero ? thc_pkg::ROUND_HALF
                         : thc_pkg::rnd_t'(z_in) + thc_pkg::ROUND_HALF;
        r  = thc_pkg::sum_t'(zb >>> thc_pkg::FRAC_DROP);
        if (r > thc_pkg::HEAD_CLAMP)
        begin
            h_next = thc_pkg::HEAD_CLAMP;
        end
        else if (r < -thc_pkg::HEAD_CLAMP)
        begin
            h_next = -thc_pkg::HEAD_CLAMP;
        end
        else
        begin
            h_next = r;
        end
    end

    always_comb
    begin
        s      = thc_pkg::sum_t'(h_reg) + thc_pkg::sum_t'(decl);
        s_next = thc_pkg::sum_t'(h_reg);
        if (decl != '0)
        begin
            if (s > thc_pkg::HEAD_PI)
            begin
                s_next = s - thc_pkg::HEAD_2PI;
            end
            else if (s < -thc_pkg::HEAD_PI)
            begin
                s_next = s + thc_pkg::HEAD_2PI;
            end
            else
            begin
                s_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= ctl_in.valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg       <= h_next[thc_pkg::FIELD_W-1:0];
            heading_reg <= s_next[thc_pkg::FIELD_W-1:0];
        end
    end

    assign out_valid = vb_reg;
    assign heading   = heading_reg;

endmodule

`default_nettype wire

### sv/tilt_compensated_heading.sv
// ============================================================================
// tilt_compensated_heading
// tilt-compensated compass heading: atan2 of the leveled field via cordic
// ============================================================================
// throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and not taken, so input ready follows output ready
// reset: pipeline valid bits cleared, declination register cleared to 0
// ============================================================================
`default_nettype none

module tilt_compensated_heading
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [15:0] field_x,
    input  wire logic signed [15:0] field_y,
    input  wire logic signed [15:0] field_z,
    input  wire logic signed [15:0] dcm_cx,
    input  wire logic signed [15:0] dcm_cy,
    input  wire logic signed [15:0] dcm_cz,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [15:0]     heading,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic signed [15:0] declination
);

    logic               en;
    logic               hv_valid;
    thc_pkg::hv_t       hx, hy_neg;
    thc_pkg::pipe_ctl_t norm_ctl, cordic_ctl;
    thc_pkg::cw_t       norm_x, norm_y;
    thc_pkg::ang_t      norm_z, cordic_z;
    thc_pkg::field_t    decl_reg;
    thc_pkg::field_t    heading_w;

    // global advance: stall only when a finished beat is not taken
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg_valid)
        begin
            decl_reg <= declination;
        end
    end

    thc_tilt u_tilt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .fx       (field_x),
        .fy       (field_y),
        .fz       (field_z),
        .cx       (dcm_cx),
        .cy       (dcm_cy),
        .cz       (dcm_cz),
        .hv_valid (hv_valid),
        .hx       (hx),
        .hy_neg   (hy_neg)
    );

    thc_norm u_norm
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .hv_valid (hv_valid),
        .hx       (hx),
        .hy_neg   (hy_neg),
        .ctl_out  (norm_ctl),
        .x_out    (norm_x),
        .y_out    (norm_y),
        .z_out    (norm_z)
    );

    thc_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (norm_ctl),
        .x_in    (norm_x),
        .y_in    (norm_y),
        .z_in    (norm_z),
        .ctl_out (cordic_ctl),
        .z_out   (cordic_z)
    );

    thc_output u_output
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (cordic_ctl),
        .z_in      (cordic_z),
        .decl      (decl_reg),
        .out_valid (out_valid),
        .heading   (heading_w)
    );

    assign heading = heading_w;

endmodule

`default_nettype wire
